/* sv/mie_pkg.sv */
// Shared types and constants for the MessagePack element encoder.
`timescale 1ns / 1ps
`default_nettype none
package mie_pkg;

  localparam int NUM_CELLS = 9;

  typedef enum logic [4:0] {
    ACT_NIL     = 5'd0,
    ACT_FALSE   = 5'd1,
    ACT_TRUE    = 5'd2,
    ACT_POSFIX  = 5'd3,
    ACT_NEGFIX  = 5'd4,
    ACT_UINT8   = 5'd5,
    ACT_UINT16  = 5'd6,
    ACT_UINT32  = 5'd7,
    ACT_UINT64  = 5'd8,
    ACT_INT8    = 5'd9,
    ACT_INT16   = 5'd10,
    ACT_INT32   = 5'd11,
    ACT_INT64   = 5'd12,
    ACT_FLOAT32 = 5'd13,
    ACT_FLOAT64 = 5'd14,
    ACT_STR     = 5'd15,
    ACT_BIN     = 5'd16,
    ACT_ARRAY   = 5'd17,
    ACT_MAP     = 5'd18,
    ACT_EXT     = 5'd19,
    ACT_BODY    = 5'd20
  } action_t;

  // One byte slot of the output chain.
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic       last;
    logic       err;
  } cell_t;

  localparam cell_t CELL_EMPTY = '{vld: 1'b0, data: 8'h00, last: 1'b0, err: 1'b0};

  localparam logic [7:0] MK_NIL     = 8'hc0;
  localparam logic [7:0] MK_FALSE   = 8'hc2;
  localparam logic [7:0] MK_TRUE    = 8'hc3;
  localparam logic [7:0] MK_NEGFIX  = 8'he0;
  localparam logic [7:0] MK_UINT8   = 8'hcc;
  localparam logic [7:0] MK_UINT16  = 8'hcd;
  localparam logic [7:0] MK_UINT32  = 8'hce;
  localparam logic [7:0] MK_UINT64  = 8'hcf;
  localparam logic [7:0] MK_INT8    = 8'hd0;
  localparam logic [7:0] MK_INT16   = 8'hd1;
  localparam logic [7:0] MK_INT32   = 8'hd2;
  localparam logic [7:0] MK_INT64   = 8'hd3;
  localparam logic [7:0] MK_FLOAT32 = 8'hca;
  localparam logic [7:0] MK_FLOAT64 = 8'hcb;
  localparam logic [7:0] MK_FIXSTR  = 8'ha0;
  localparam logic [7:0] MK_STR8    = 8'hd9;
  localparam logic [7:0] MK_STR16   = 8'hda;
  localparam logic [7:0] MK_STR32   = 8'hdb;
  localparam logic [7:0] MK_BIN8    = 8'hc4;
  localparam logic [7:0] MK_BIN16   = 8'hc5;
  localparam logic [7:0] MK_BIN32   = 8'hc6;
  localparam logic [7:0] MK_FIXARR  = 8'h90;
  localparam logic [7:0] MK_ARR16   = 8'hdc;
  localparam logic [7:0] MK_ARR32   = 8'hdd;
  localparam logic [7:0] MK_FIXMAP  = 8'h80;
  localparam logic [7:0] MK_MAP16   = 8'hde;
  localparam logic [7:0] MK_MAP32   = 8'hdf;
  localparam logic [7:0] MK_FIXEXT1 = 8'hd4;
  localparam logic [7:0] MK_FIXEXT2 = 8'hd5;
  localparam logic [7:0] MK_FIXEXT4 = 8'hd6;
  localparam logic [7:0] MK_FIXEXT8 = 8'hd7;
  localparam logic [7:0] MK_FIXEXT16 = 8'hd8;
  localparam logic [7:0] MK_EXT8    = 8'hc7;
  localparam logic [7:0] MK_EXT16   = 8'hc8;
  localparam logic [7:0] MK_EXT32   = 8'hc9;

endpackage
`default_nettype wire

/* sv/mie_decode.sv */
// Element decoder: turns one element into the byte image loaded into the chain.
`timescale 1ns / 1ps
`default_nettype none
module mie_decode (
  input  wire logic [4:0]  action,
  input  wire logic [63:0] value,
  input  wire logic [7:0]  ext_type,
  output mie_pkg::cell_t   cells [mie_pkg::NUM_CELLS]
);

  logic [7:0] marker;
  logic [3:0] nbody;
  logic       tail;
  logic       known;
  logic       err;
  logic [3:0] nbytes;
  logic [2:0] sh;
  logic [7:0] byte_k;
  logic       lt16, lt32, lt256, lt64k, big;
  logic [3:0] cls;

  assign lt16  = (value[63:4] == '0);
  assign lt32  = (value[63:5] == '0);
  assign lt256 = (value[63:8] == '0);
  assign lt64k = (value[63:16] == '0);
  assign big   = (value[63:32] != '0);
  assign cls   = lt256 ? 4'd1 : (lt64k ? 4'd2 : 4'd4);

  always_comb begin
    marker = 8'h00;
    nbody  = 4'd0;
    tail   = 1'b0;
    known  = 1'b1;
    err    = 1'b0;
    case (mie_pkg::action_t'(action))
      mie_pkg::ACT_NIL:     marker = mie_pkg::MK_NIL;
      mie_pkg::ACT_FALSE:   marker = mie_pkg::MK_FALSE;
      mie_pkg::ACT_TRUE:    marker = mie_pkg::MK_TRUE;
      mie_pkg::ACT_POSFIX:  marker = {1'b0, value[6:0]};
      mie_pkg::ACT_NEGFIX:  marker = mie_pkg::MK_NEGFIX | {3'b000, value[4:0]};
      mie_pkg::ACT_UINT8:   begin marker = mie_pkg::MK_UINT8;   nbody = 4'd1; end
      mie_pkg::ACT_UINT16:  begin marker = mie_pkg::MK_UINT16;  nbody = 4'd2; end
      mie_pkg::ACT_UINT32:  begin marker = mie_pkg::MK_UINT32;  nbody = 4'd4; end
      mie_pkg::ACT_UINT64:  begin marker = mie_pkg::MK_UINT64;  nbody = 4'd8; end
      mie_pkg::ACT_INT8:    begin marker = mie_pkg::MK_INT8;    nbody = 4'd1; end
      mie_pkg::ACT_INT16:   begin marker = mie_pkg::MK_INT16;   nbody = 4'd2; end
      mie_pkg::ACT_INT32:   begin marker = mie_pkg::MK_INT32;   nbody = 4'd4; end
      mie_pkg::ACT_INT64:   begin marker = mie_pkg::MK_INT64;   nbody = 4'd8; end
      mie_pkg::ACT_FLOAT32: begin marker = mie_pkg::MK_FLOAT32; nbody = 4'd4; end
      mie_pkg::ACT_FLOAT64: begin marker = mie_pkg::MK_FLOAT64; nbody = 4'd8; end
      mie_pkg::ACT_STR: begin
        err = big;
        if (lt32) begin
          marker = mie_pkg::MK_FIXSTR | {3'b000, value[4:0]};
        end else begin
          nbody  = cls;
          marker = lt256 ? mie_pkg::MK_STR8 : (lt64k ? mie_pkg::MK_STR16 : mie_pkg::MK_STR32);
        end
      end
      mie_pkg::ACT_BIN: begin
        err    = big;
        nbody  = cls;
        marker = lt256 ? mie_pkg::MK_BIN8 : (lt64k ? mie_pkg::MK_BIN16 : mie_pkg::MK_BIN32);
      end
      mie_pkg::ACT_ARRAY, mie_pkg::ACT_MAP: begin
        err = big;
        if (lt16) begin
          marker = ((action == mie_pkg::ACT_MAP) ? mie_pkg::MK_FIXMAP : mie_pkg::MK_FIXARR)
                   | {4'h0, value[3:0]};
        end else if (lt64k) begin
          nbody  = 4'd2;
          marker = (action == mie_pkg::ACT_MAP) ? mie_pkg::MK_MAP16 : mie_pkg::MK_ARR16;
        end else begin
          nbody  = 4'd4;
          marker = (action == mie_pkg::ACT_MAP) ? mie_pkg::MK_MAP32 : mie_pkg::MK_ARR32;
        end
      end
      mie_pkg::ACT_EXT: begin
        err  = big;
        tail = 1'b1;
        if (value == 64'd1) begin
          marker = mie_pkg::MK_FIXEXT1;
        end else if (value == 64'd2) begin
          marker = mie_pkg::MK_FIXEXT2;
        end else if (value == 64'd4) begin
          marker = mie_pkg::MK_FIXEXT4;
        end else if (value == 64'd8) begin
          marker = mie_pkg::MK_FIXEXT8;
        end else if (value == 64'd16) begin
          marker = mie_pkg::MK_FIXEXT16;
        end else begin
          nbody  = cls;
          marker = lt256 ? mie_pkg::MK_EXT8 : (lt64k ? mie_pkg::MK_EXT16 : mie_pkg::MK_EXT32);
        end
      end
      mie_pkg::ACT_BODY:    marker = value[7:0];
      default:              known = 1'b0;
    endcase
  end

  // Byte count of the element; zero for an unused action code.
  assign nbytes = known ? (4'd1 + nbody + {3'b000, tail}) : 4'd0;

  always_comb begin
    sh     = 3'd0;
    byte_k = 8'h00;
    for (int k = 0; k < mie_pkg::NUM_CELLS; k++) begin
      if (k == 0) begin
        byte_k = marker;
      end else if (4'(k) <= nbody) begin
        sh     = 3'(nbody - 4'(k));
        byte_k = 8'(value >> {sh, 3'b000});
      end else begin
        byte_k = ext_type;
      end
      cells[k].vld  = (4'(k) < nbytes);
      cells[k].data = byte_k;
      cells[k].last = (4'(k) + 4'd1 == nbytes);
      cells[k].err  = err;
    end
  end

endmodule
`default_nettype wire

/* sv/mie_cell.sv */
// One byte cell of the output chain: loads in parallel, shifts toward the head.
`timescale 1ns / 1ps
`default_nettype none
module mie_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,
  input  wire logic           shift,
  input  wire mie_pkg::cell_t load_data,
  input  wire mie_pkg::cell_t from_next,
  output mie_pkg::cell_t      cell_q
);

  mie_pkg::cell_t cell_r;
  mie_pkg::cell_t cell_nxt;

  always_comb begin
    cell_nxt = cell_r;
    if (load) begin
      cell_nxt = load_data;
    end else if (shift) begin
      cell_nxt = from_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else begin
      cell_r.vld <= cell_nxt.vld;
    end
    cell_r.data <= cell_nxt.data;
    cell_r.last <= cell_nxt.last;
    cell_r.err  <= cell_nxt.err;
  end

  assign cell_q = cell_r;

endmodule
`default_nettype wire

/* sv/msgpack_item_encoder_core.sv */
// Top level of the MessagePack element encoder: input register, decoder, byte chain.
// The first output byte passes from the input register through cell 0 of the chain into
// the output register.
// An element is 1 to 9 bytes long; the chain of nine byte cells drains one byte per cycle
// into the output register whenever that register is free or its byte is being taken.
// The next element is loaded while the previous element's last byte waits at the output.
// Reset (rst_n low, synchronous) empties the input register, the chain and the output.
`timescale 1ns / 1ps
`default_nettype none
module msgpack_item_encoder_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [4:0]        in_action,
  input  wire logic [63:0]       in_value,
  input  wire logic signed [7:0] in_ext_type,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_byte,
  output logic                   out_last,
  output logic                   out_length_error
);

  localparam int NC = mie_pkg::NUM_CELLS;

  // Input register holding one element until the chain can take it.
  logic        in_v_r;
  logic        in_v_nxt;
  logic [4:0]  act_r;
  logic [63:0] val_r;
  logic [7:0]  etype_r;
  logic        in_xfer;

  // Chain control: shift whenever the output register can take a byte.
  logic           shift;
  logic           load;
  mie_pkg::cell_t dec_cells [NC];
  mie_pkg::cell_t chain     [NC];
  mie_pkg::cell_t out_r;
  mie_pkg::cell_t out_nxt;

  assign shift = !out_r.vld || !out_stall;

  // Bytes sit packed from cell 0, so the chain is empty after this cycle when
  // cell 0 is empty, or when it is moving out and cell 1 is empty.
  assign load = in_v_r && (!chain[0].vld || (shift && !chain[1].vld));

  assign in_stall = in_v_r && !load;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_xfer) begin
      in_v_nxt = 1'b1;
    end else if (load) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
    if (in_xfer) begin
      act_r   <= in_action;
      val_r   <= in_value;
      etype_r <= in_ext_type;
    end
  end

  mie_decode u_decode (
    .action   (act_r),
    .value    (val_r),
    .ext_type (etype_r),
    .cells    (dec_cells)
  );

  // The chain of byte cells; the tail cell takes an empty slot when shifting.
  for (genvar g = 0; g < NC; g++) begin : g_chain
    mie_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .load      (load),
      .shift     (shift),
      .load_data (dec_cells[g]),
      .from_next ((g == NC - 1) ? mie_pkg::CELL_EMPTY : chain[(g + 1) % NC]),
      .cell_q    (chain[g])
    );
  end

  // Output register: takes the head byte whenever it is free or being transferred.
  always_comb begin
    out_nxt = out_r;
    if (shift) begin
      out_nxt = chain[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.vld <= 1'b0;
    end else begin
      out_r.vld <= out_nxt.vld;
    end
    out_r.data <= out_nxt.data;
    out_r.last <= out_nxt.last;
    out_r.err  <= out_nxt.err;
  end

  assign out_valid        = out_r.vld;
  assign out_byte         = out_r.data;
  assign out_last         = out_r.last;
  assign out_length_error = out_r.err;

endmodule
`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the MessagePack element encoder core.
`timescale 1ns / 1ps
module tb;
  import mie_pkg::*;

  // Action codes that name no element; the encoder must drop them silently.
  localparam logic [4:0] ACT_UNUSED_FIRST = 5'd21;
  localparam logic [4:0] ACT_UNUSED_LAST  = 5'd31;

  localparam logic [63:0] LEN32_LIMIT = 64'hffff_ffff;
  localparam int RANDOM_ITEMS = 480;
  localparam int HOLD_OFF_CYCLES = 250;
  // Cycles allowed after the last expected byte for anything still in flight
  // (the input, chain and output registers plus a full nine-byte element, with margin).
  localparam int DRAIN_TAIL = 16;
  localparam int MAX_SHOWN = 10;

  // One expected output byte.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } enc_byte_t;

  // One row of the directed stimulus. When known is set, the expected bytes are
  // typed in the row: nbytes bytes right-aligned in bytes, first byte leftmost.
  typedef struct {
    logic [4:0]  act;
    logic [63:0] val;
    logic [7:0]  etype;
    bit          known;
    int          nbytes;
    logic [71:0] bytes;
    bit          err;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [4:0]  in_action = '0;
  logic [63:0] in_value = '0;
  logic [7:0]  in_ext_type = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_length_error;

  enc_byte_t pending_bytes [$];
  enc_byte_t exp_b;
  stim_row_t stim_rows [$];
  int        fail_cnt = 0;
  int        shown_cnt = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  // The main sequence bumps rx_hold_seq to ask for a long receiver hold-off;
  // the receiver process owns the countdown.
  int        rx_hold_seq = 0;
  int        rx_hold_seen = 0;
  int        rx_hold_left = 0;

  msgpack_item_encoder_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_value         (in_value),
    .in_ext_type      (in_ext_type),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last         (out_last),
    .out_length_error (out_length_error)
  );

  always #5 clk = ~clk;

  // Smallest length class (in bytes) that holds a header length.
  function automatic int len_bytes(input logic [63:0] v);
    if (v < 64'd256) return 1;
    if (v < 64'd65536) return 2;
    return 4;
  endfunction

  // Works out the byte sequence of one element and queues it. Every element is
  // a head byte, nb big-endian bytes of the value, and for ext headers a
  // trailing type byte.
  function automatic void encode_element(input logic [4:0] act, input logic [63:0] val,
                                         input logic [7:0] etype);
    logic [7:0] head;
    int         nb;
    int         total;
    bit         has_head;
    bit         has_tail;
    bit         err;
    enc_byte_t  eb;
    head = '0;
    nb = 0;
    has_head = 1'b1;
    has_tail = 1'b0;
    err = 1'b0;
    case (act)
      ACT_NIL:     head = MK_NIL;
      ACT_FALSE:   head = MK_FALSE;
      ACT_TRUE:    head = MK_TRUE;
      ACT_POSFIX:  head = {1'b0, val[6:0]};
      ACT_NEGFIX:  head = MK_NEGFIX | {3'b000, val[4:0]};
      ACT_UINT8: begin head = MK_UINT8; nb = 1; end
      ACT_UINT16: begin head = MK_UINT16; nb = 2; end
      ACT_UINT32: begin head = MK_UINT32; nb = 4; end
      ACT_UINT64: begin head = MK_UINT64; nb = 8; end
      ACT_INT8: begin head = MK_INT8; nb = 1; end
      ACT_INT16: begin head = MK_INT16; nb = 2; end
      ACT_INT32: begin head = MK_INT32; nb = 4; end
      ACT_INT64: begin head = MK_INT64; nb = 8; end
      ACT_FLOAT32: begin head = MK_FLOAT32; nb = 4; end
      ACT_FLOAT64: begin head = MK_FLOAT64; nb = 8; end
      ACT_STR: begin
        err = val > LEN32_LIMIT;
        if (val < 64'd32) begin
          head = MK_FIXSTR | {3'b000, val[4:0]};
        end else begin
          nb = len_bytes(val);
          head = (nb == 1) ? MK_STR8 : ((nb == 2) ? MK_STR16 : MK_STR32);
        end
      end
      ACT_BIN: begin
        err = val > LEN32_LIMIT;
        nb = len_bytes(val);
        head = (nb == 1) ? MK_BIN8 : ((nb == 2) ? MK_BIN16 : MK_BIN32);
      end
      ACT_ARRAY, ACT_MAP: begin
        err = val > LEN32_LIMIT;
        if (val < 64'd16) begin
          head = ((act == ACT_MAP) ? MK_FIXMAP : MK_FIXARR) | {4'h0, val[3:0]};
        end else if (val < 64'd65536) begin
          nb = 2;
          head = (act == ACT_MAP) ? MK_MAP16 : MK_ARR16;
        end else begin
          nb = 4;
          head = (act == ACT_MAP) ? MK_MAP32 : MK_ARR32;
        end
      end
      ACT_EXT: begin
        err = val > LEN32_LIMIT;
        has_tail = 1'b1;
        case (val)
          64'd1:  head = MK_FIXEXT1;
          64'd2:  head = MK_FIXEXT2;
          64'd4:  head = MK_FIXEXT4;
          64'd8:  head = MK_FIXEXT8;
          64'd16: head = MK_FIXEXT16;
          default: begin
            nb = len_bytes(val);
            head = (nb == 1) ? MK_EXT8 : ((nb == 2) ? MK_EXT16 : MK_EXT32);
          end
        endcase
      end
      ACT_BODY: head = val[7:0];
      default: has_head = 1'b0;
    endcase
    total = has_head ? (1 + nb + int'(has_tail)) : 0;
    for (int k = 0; k < total; k++) begin
      if (k == 0) eb.data = head;
      else if (k <= nb) eb.data = val[8 * (nb - k) +: 8];
      else eb.data = etype;
      eb.last = (k == total - 1);
      eb.err = err;
      pending_bytes.push_back(eb);
    end
  endfunction

  // Offers one element on the input channel and records what it must produce
  // at the edge where the transfer happens. The sender may idle first.
  task automatic send_item(input logic [4:0] act, input logic [63:0] val,
                           input logic [7:0] etype, input bit known, input int nbytes,
                           input logic [71:0] bytes, input bit err);
    enc_byte_t eb;
    @(negedge clk);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_value <= val;
    in_ext_type <= etype;
    do @(posedge clk); while (in_stall);
    if (known) begin
      for (int k = 0; k < nbytes; k++) begin
        eb.data = bytes[8 * (nbytes - 1 - k) +: 8];
        eb.last = (k == nbytes - 1);
        eb.err = err;
        pending_bytes.push_back(eb);
      end
    end else begin
      encode_element(act, val, etype);
    end
  endtask

  // Header lengths: across all classes, some at class boundaries, sometimes beyond 32 bits.
  function automatic logic [63:0] rand_len();
    case ($urandom_range(7, 0))
      0: return 64'($urandom_range(31, 0));
      1: begin
        case ($urandom_range(4, 0))
          0: return 64'd16 - 64'($urandom_range(1, 0));
          1: return 64'd32 - 64'($urandom_range(1, 0));
          2: return 64'd256 - 64'($urandom_range(1, 0));
          3: return 64'd65536 - 64'($urandom_range(1, 0));
          default: return 64'h1_0000_0000 - 64'($urandom_range(1, 0));
        endcase
      end
      2: return 64'($urandom_range(255, 0));
      3: return 64'($urandom_range(65535, 0));
      4: return {32'h0, $urandom()};
      5: return {$urandom(), $urandom()};
      6: return 64'd1 << $urandom_range(4, 0);
      default: return 64'($urandom_range(20, 0));
    endcase
  endfunction

  function automatic logic [63:0] rand_data();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(63, 0);
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // One random element. Unused action codes are sent now and then but do not
  // count as items, since the encoder ignores them.
  task automatic send_random(output bit counted);
    logic [4:0]  act;
    logic [63:0] val;
    int          pick;
    pick = $urandom_range(99, 0);
    if (pick < 5) act = 5'($urandom_range(ACT_UNUSED_LAST, ACT_UNUSED_FIRST));
    else if (pick < 15) act = ACT_BODY;
    else if (pick < 55) act = 5'($urandom_range(ACT_EXT, ACT_STR));
    else act = 5'($urandom_range(ACT_FLOAT64, ACT_NIL));
    val = (act >= ACT_STR && act <= ACT_EXT) ? rand_len() : rand_data();
    counted = (act <= ACT_BODY);
    send_item(act, val, 8'($urandom()), 1'b0, 0, '0, 1'b0);
  endtask

  // The sender stops until every expected byte has come out, then allows a
  // few more cycles so that anything unexpected still shows up.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested. Only
  // this process touches out_stall, once per falling edge.
  always @(negedge clk) begin
    if (rx_hold_seq != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_seq;
      rx_hold_left <= HOLD_OFF_CYCLES;
      out_stall <= 1'b1;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  // Every output transfer is matched against the oldest expected byte.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        fail_cnt++;
        if (shown_cnt < MAX_SHOWN) begin
          shown_cnt++;
          $display("unexpected output: byte %02h last %0b err %0b",
                   out_byte, out_last, out_length_error);
        end
      end else begin
        exp_b = pending_bytes.pop_front();
        if (exp_b != {out_byte, out_last, out_length_error}) begin
          fail_cnt++;
          if (shown_cnt < MAX_SHOWN) begin
            shown_cnt++;
            $display("mismatch: expected byte %02h last %0b err %0b, got byte %02h last %0b err %0b",
                     exp_b.data, exp_b.last, exp_b.err, out_byte, out_last, out_length_error);
          end
        end
      end
    end
  end

  initial begin
    int  done_items;
    bit  counted;

    // Directed rows: extremes of each field, every action, several length class
    // edges, oversized lengths and unused codes.
    stim_rows.push_back('{ACT_NIL, 64'd0, 8'h00, 1'b1, 1, 72'hc0, 1'b0});
    stim_rows.push_back('{ACT_FALSE, '1, 8'hff, 1'b1, 1, 72'hc2, 1'b0});
    stim_rows.push_back('{ACT_TRUE, 64'd0, 8'h00, 1'b1, 1, 72'hc3, 1'b0});
    stim_rows.push_back('{ACT_POSFIX, '1, 8'h00, 1'b1, 1, 72'h7f, 1'b0});
    stim_rows.push_back('{ACT_NEGFIX, '1, 8'h00, 1'b1, 1, 72'hff, 1'b0});
    stim_rows.push_back('{ACT_UINT8, '1, 8'h00, 1'b1, 2, 72'hcc_ff, 1'b0});
    stim_rows.push_back('{ACT_UINT16, 64'h1234_5678_9abc_def0, 8'h00, 1'b0, 0, '0, 1'b0});
    stim_rows.push_back('{ACT_UINT32, 64'h1234_5678_9abc_def0, 8'h00, 1'b0, 0, '0, 1'b0});
    stim_rows.push_back('{ACT_UINT64, '1, 8'h00, 1'b1, 9, 72'hcf_ffff_ffff_ffff_ffff, 1'b0});
    stim_rows.push_back('{ACT_INT8, 64'h0000_0000_0000_0080, 8'h00, 1'b0, 0, '0, 1'b0});
    stim_rows.push_back('{ACT_INT16, 64'hffff_ffff_ffff_8000, 8'h00, 1'b0, 0, '0, 1'b0});
    stim_rows.push_back('{ACT_INT32, 64'h0000_0000_7fff_ffff, 8'h00, 1'b0, 0, '0, 1'b0});
    stim_rows.push_back('{ACT_INT64, 64'h8000_0000_0000_0000, 8'h00, 1'b1, 9,
                          72'hd3_8000_0000_0000_0000, 1'b0});
    stim_rows.push_back('{ACT_FLOAT32, 64'h0000_0000_3f80_0000, 8'h00, 1'b0, 0, '0, 1'b0});
    stim_rows.push_back('{ACT_FLOAT64, 64'h4009_21fb_5444_2d18, 8'h00, 1'b0, 0, '0, 1'b0});
    stim_rows.push_back('{ACT_STR, 64'd31, 8'h00, 1'b1, 1, 72'hbf, 1'b0});
    stim_rows.push_back('{ACT_STR, '1, 8'h00, 1'b1, 5, 72'hdb_ffff_ffff, 1'b1});
    stim_rows.push_back('{ACT_BIN, 64'd0, 8'h00, 1'b1, 2, 72'hc4_00, 1'b0});
    stim_rows.push_back('{ACT_ARRAY, 64'd15, 8'h00, 1'b1, 1, 72'h9f, 1'b0});
    stim_rows.push_back('{ACT_MAP, 64'h1_0000_0000, 8'h00, 1'b1, 5, 72'hdf_0000_0000, 1'b1});
    stim_rows.push_back('{ACT_EXT, 64'd1, 8'h80, 1'b1, 2, 72'hd4_80, 1'b0});
    stim_rows.push_back('{ACT_EXT, 64'd0, 8'h7f, 1'b0, 0, '0, 1'b0});
    stim_rows.push_back('{ACT_EXT, 64'd65536, 8'hff, 1'b0, 0, '0, 1'b0});
    stim_rows.push_back('{ACT_BODY, 64'hffff_ffff_ffff_ffab, 8'h00, 1'b1, 1, 72'hab, 1'b0});
    stim_rows.push_back('{ACT_UNUSED_FIRST, '1, 8'hff, 1'b1, 0, '0, 1'b0});
    stim_rows.push_back('{ACT_UNUSED_LAST, '1, 8'hff, 1'b1, 0, '0, 1'b0});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The directed rows and the first random phase run with a sender that
    // idles lightly against a receiver that stalls most of the time.
    send_idle_pct = 38;
    recv_idle_pct = 83;
    foreach (stim_rows[i]) begin
      send_item(stim_rows[i].act, stim_rows[i].val, stim_rows[i].etype, stim_rows[i].known,
                stim_rows[i].nbytes, stim_rows[i].bytes, stim_rows[i].err);
    end
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 38; recv_idle_pct = 83; end
        1: begin send_idle_pct = 83; recv_idle_pct = 38; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      // In the phase without idling the receiver first holds off for a long
      // stretch while the sender keeps offering, so the byte chain fills and
      // the input side has to stall.
      if (phase == 2) rx_hold_seq++;
      done_items = 0;
      while (done_items < RANDOM_ITEMS / 3) begin
        send_random(counted);
        if (counted) done_items++;
      end
      drain_results();
    end

    if (fail_cnt == 0 && pending_bytes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
